[hdl/htw_pkg.sv]
package htw_pkg;

    localparam int NUM_TIMERS = 16;
    localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CNT_W      = 32;
    localparam int ID_W       = 4;
    localparam int OP_W       = 3;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TIMERS - 1);
    localparam logic [CNT_W-1:0] ALL_ONES = {CNT_W{1'b1}};

    localparam logic KIND_EXPIRY = 1'b0;
    localparam logic KIND_QUERY  = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_TICK      = 3'd0,
        OP_CONFIGURE = 3'd1,
        OP_START     = 3'd2,
        OP_STOP      = 3'd3,
        OP_QUERY     = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [ID_W-1:0]  timer_id;
        logic [CNT_W-1:0] delay;
        logic [CNT_W-1:0] period;
    } in_item_t;

    typedef struct packed {
        logic             kind;
        logic [ID_W-1:0]  expired_id;
        logic [CNT_W-1:0] remaining;
        logic             last;
    } out_item_t;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic [IDX_W-1:0] wr_addr;
        logic             dl_we;
        logic             rl_we;
        logic             arm_set;
        logic             arm_clr;
        logic [CNT_W-1:0] deadline;
        logic [CNT_W-1:0] reload;
    } store_cmd_t;

    function automatic logic id_in_range(input logic [ID_W-1:0] id);
        logic [31:0] wide;
        wide = 32'(id);
        return (wide < 32'(NUM_TIMERS));
    endfunction

    function automatic logic [IDX_W-1:0] id_to_idx(input logic [ID_W-1:0] id);
        logic [31:0] wide;
        wide = 32'(id);
        return wide[IDX_W-1:0];
    endfunction

    function automatic logic [ID_W-1:0] idx_to_id(input logic [IDX_W-1:0] idx);
        logic [31:0] wide;
        wide = 32'(idx);
        return wide[ID_W-1:0];
    endfunction

endpackage

[hdl/htw_alu.sv]
module htw_alu (
    input  logic [htw_pkg::CNT_W-1:0] a,
    input  logic [htw_pkg::CNT_W-1:0] b,
    input  logic                      sub,
    output logic [htw_pkg::CNT_W-1:0] y
);
    import htw_pkg::*;

    logic [CNT_W-1:0] b_eff;

    assign b_eff = b ^ {CNT_W{sub}};
    assign y     = a + b_eff + CNT_W'(sub);

endmodule

[hdl/htw_store.sv]
module htw_store (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  htw_pkg::store_cmd_t            cmd,
    output logic [htw_pkg::CNT_W-1:0]      rd_deadline,
    output logic [htw_pkg::CNT_W-1:0]      rd_reload,
    output logic [htw_pkg::NUM_TIMERS-1:0] armed
);
    import htw_pkg::*;

    logic [CNT_W-1:0]      deadline_mem [NUM_TIMERS];
    logic [CNT_W-1:0]      reload_mem   [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] rl_valid_reg;
    logic [NUM_TIMERS-1:0] armed_reg;
    logic [CNT_W-1:0]      rd_deadline_reg;
    logic [CNT_W-1:0]      rd_reload_reg;
    logic                  rd_rl_valid_reg;

    always_ff @(posedge aclk) begin
        if (cmd.dl_we) begin
            deadline_mem[cmd.wr_addr] <= cmd.deadline;
        end
        if (cmd.rl_we) begin
            reload_mem[cmd.wr_addr] <= cmd.reload;
        end
        if (cmd.rd_en) begin
            rd_deadline_reg <= deadline_mem[cmd.rd_addr];
            rd_reload_reg   <= reload_mem[cmd.rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rl_valid_reg    <= '0;
            armed_reg       <= '0;
            rd_rl_valid_reg <= 1'b0;
        end else begin
            if (cmd.rl_we) begin
                rl_valid_reg[cmd.wr_addr] <= 1'b1;
            end
            if (cmd.arm_set) begin
                armed_reg[cmd.wr_addr] <= 1'b1;
            end else if (cmd.arm_clr) begin
                armed_reg[cmd.wr_addr] <= 1'b0;
            end
            if (cmd.rd_en) begin
                rd_rl_valid_reg <= rl_valid_reg[cmd.rd_addr];
            end
        end
    end

    // A reload value never written reads as its reset value of zero.
    assign rd_deadline = rd_deadline_reg;
    assign rd_reload   = rd_rl_valid_reg ? rd_reload_reg : '0;
    assign armed       = armed_reg;

endmodule

[hdl/hierarchical_timer_wheel_unit.sv]
// Pool of 16 timers against a free-running 32-bit tick counter. Configure, start and
// stop are each taken in the idle state, and the block is ready again in the next
// cycle. A tick or a query walks the timer store through its single read port and
// a single shared adder, one entry per cycle unless a due timer waits on the result
// side: it takes the transfer, visits each timer, then finishes; s_ready stays low.
// A tick returns one expiry result per due timer in ascending index, the final one
// marked last; a tick with no due timer returns nothing. A query returns exactly
// one result holding the smallest remaining time, or zero when no timer is armed.
module hierarchical_timer_wheel_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  htw_pkg::in_item_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output htw_pkg::out_item_t  m_data
);
    import htw_pkg::*;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] tick_count_reg, tick_count_next;
    logic             query_reg, query_next;
    logic             pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0] pend_id_reg, pend_id_next;
    logic [CNT_W-1:0] best_reg, best_next;
    logic             any_reg, any_next;
    logic             m_valid_reg, m_valid_next;
    out_item_t        m_data_reg, m_data_next;

    store_cmd_t            cmd;
    logic [CNT_W-1:0]      rd_deadline;
    logic [CNT_W-1:0]      rd_reload;
    logic [NUM_TIMERS-1:0] armed;

    logic [CNT_W-1:0] alu_a;
    logic [CNT_W-1:0] alu_b;
    logic             alu_sub;
    logic [CNT_W-1:0] alu_y;

    logic      out_free;
    logic      hit;
    logic      stall;
    logic      out_load;
    out_item_t out_item;

    htw_store u_store (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .rd_deadline (rd_deadline),
        .rd_reload   (rd_reload),
        .armed       (armed)
    );

    htw_alu u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .sub (alu_sub),
        .y   (alu_y)
    );

    assign out_free = !m_valid_reg || m_ready;
    assign hit      = !query_reg && armed[idx_reg] && (rd_deadline == tick_count_reg);
    assign stall    = hit && pend_valid_reg && !out_free;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && (s_data.op == OP_TICK || s_data.op == OP_QUERY)) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (!stall && idx_reg == LAST_IDX) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!(query_reg || pend_valid_reg) || out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd             = '0;
        cmd.reload      = s_data.period;
        cmd.deadline    = alu_y;
        alu_a           = tick_count_reg;
        alu_b           = CNT_W'(1);
        alu_sub         = 1'b0;
        s_ready         = 1'b0;
        out_load        = 1'b0;
        out_item        = '0;
        idx_next        = idx_reg;
        tick_count_next = tick_count_reg;
        query_next      = query_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        best_next       = best_reg;
        any_next        = any_reg;

        unique case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.wr_addr = id_to_idx(s_data.timer_id);
                if (s_data.op != OP_TICK) begin
                    alu_b = s_data.delay;
                end
                if (s_valid) begin
                    unique case (s_data.op)
                        OP_TICK: begin
                            tick_count_next = alu_y;
                            cmd.rd_en       = 1'b1;
                            idx_next        = '0;
                            query_next      = 1'b0;
                            pend_valid_next = 1'b0;
                        end
                        OP_CONFIGURE: begin
                            if (id_in_range(s_data.timer_id)) begin
                                cmd.rl_we = 1'b1;
                                if (s_data.delay != '0) begin
                                    cmd.dl_we   = 1'b1;
                                    cmd.arm_set = 1'b1;
                                end else begin
                                    cmd.arm_clr = 1'b1;
                                end
                            end
                        end
                        OP_START: begin
                            if (id_in_range(s_data.timer_id) && s_data.delay != '0) begin
                                cmd.dl_we   = 1'b1;
                                cmd.arm_set = 1'b1;
                            end
                        end
                        OP_STOP: begin
                            if (id_in_range(s_data.timer_id)) begin
                                cmd.arm_clr = 1'b1;
                            end
                        end
                        OP_QUERY: begin
                            cmd.rd_en  = 1'b1;
                            idx_next   = '0;
                            query_next = 1'b1;
                            best_next  = ALL_ONES;
                            any_next   = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                cmd.wr_addr = idx_reg;
                cmd.rd_addr = idx_reg + IDX_W'(1);
                if (query_reg) begin
                    alu_a   = rd_deadline;
                    alu_b   = tick_count_reg;
                    alu_sub = 1'b1;
                end else begin
                    alu_b = rd_reload;
                end
                if (!stall) begin
                    if (query_reg) begin
                        if (armed[idx_reg]) begin
                            any_next = 1'b1;
                            if (alu_y < best_reg) begin
                                best_next = alu_y;
                            end
                        end
                    end else if (hit) begin
                        if (pend_valid_reg) begin
                            out_load            = 1'b1;
                            out_item.kind       = KIND_EXPIRY;
                            out_item.expired_id = idx_to_id(pend_id_reg);
                        end
                        pend_valid_next = 1'b1;
                        pend_id_next    = idx_reg;
                        if (rd_reload != '0) begin
                            cmd.dl_we = 1'b1;
                        end else begin
                            cmd.arm_clr = 1'b1;
                        end
                    end
                    if (idx_reg != LAST_IDX) begin
                        cmd.rd_en = 1'b1;
                        idx_next  = idx_reg + IDX_W'(1);
                    end
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    if (query_reg) begin
                        out_load           = 1'b1;
                        out_item.kind      = KIND_QUERY;
                        out_item.remaining = any_reg ? best_reg : '0;
                        out_item.last      = 1'b1;
                    end else if (pend_valid_reg) begin
                        out_load            = 1'b1;
                        out_item.kind       = KIND_EXPIRY;
                        out_item.expired_id = idx_to_id(pend_id_reg);
                        out_item.last       = 1'b1;
                        pend_valid_next     = 1'b0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        m_data_next  = out_load ? out_item : m_data_reg;
        m_valid_next = out_load || (m_valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            tick_count_reg <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            query_reg      <= 1'b0;
            idx_reg        <= '0;
        end else begin
            state_reg      <= state_next;
            tick_count_reg <= tick_count_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
            query_reg      <= query_next;
            idx_reg        <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_id_reg <= pend_id_next;
        best_reg    <= best_next;
        any_reg     <= any_next;
        m_data_reg  <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_load_only_when_free: assert property (
        @(posedge aclk) disable iff (!aresetn)
        out_load |-> out_free
    ) else $error("result register overwritten before its transfer");

    a_tick_advances: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.op == OP_TICK)
            |=> (tick_count_reg == $past(tick_count_reg) + CNT_W'(1))
    ) else $error("tick counter did not advance by one");

    a_idle_has_no_pending: assert property (
        @(posedge aclk) disable iff (!aresetn)
        s_ready |-> !pend_valid_reg
    ) else $error("expiry result left behind when returning to idle");

    a_query_zero_iff_none: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (out_load && out_item.kind == KIND_QUERY) |-> ((out_item.remaining != '0) == any_reg)
    ) else $error("query answer disagrees with armed timer set");

endmodule

[sim/testbench.sv]
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import htw_pkg::*;

    localparam int unsigned RUN_LIMIT     = 400000;
    localparam int unsigned PHASE_ITEMS   = 26;
    localparam int unsigned SETTLE_CYCLES = 40;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned PRESSURE_TICKS = 5;
    localparam int unsigned REPORT_CAP    = 25;

    localparam logic [OP_W-1:0] OP_RSVD_FIRST = OP_QUERY + 1'b1;
    localparam logic [OP_W-1:0] OP_RSVD_LAST  = '1;

    typedef struct {
        in_item_t  item;
        logic      typed;
        out_item_t want;
    } dir_row_t;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    in_item_t   s_data;
    logic       m_valid;
    logic       m_ready;
    out_item_t  m_data;

    logic [CNT_W-1:0] now_count;
    logic [CNT_W-1:0] due_at [NUM_TIMERS];
    logic [CNT_W-1:0] reload_len [NUM_TIMERS];
    logic             live [NUM_TIMERS];

    out_item_t   fresh_results [$];
    out_item_t   awaited_results [$];
    dir_row_t    directed_rows [$];

    int unsigned src_idle_pct;
    int unsigned sink_stall_pct;
    int unsigned hold_left;
    int unsigned cycle_count;
    int unsigned error_count;
    int unsigned result_count;

    int unsigned src_pct_tab [4]  = '{0, 79, 0, 25};
    int unsigned sink_pct_tab [4] = '{0, 0, 79, 25};

    hierarchical_timer_wheel_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count > RUN_LIMIT) begin
            $display("Timed out after %0d cycles", cycle_count);
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        error_count = error_count + 1;
        if (error_count <= REPORT_CAP) begin
            $display("[%0t] result %0d: %s", $realtime, result_count, msg);
        end
    endtask

    // Advances the timer pool by one item and leaves its results in fresh_results.
    task automatic model_item(input in_item_t it);
        int unsigned      idx;
        logic [CNT_W-1:0] best;
        logic [CNT_W-1:0] gap;
        logic             any;
        out_item_t        res;
        fresh_results.delete();
        idx = it.timer_id;
        case (it.op) inside
            OP_TICK: begin
                now_count = now_count + 1'b1;
                for (int i = 0; i < NUM_TIMERS; i++) begin
                    if (live[i] && due_at[i] == now_count) begin
                        res = '{KIND_EXPIRY, ID_W'(i), '0, 1'b0};
                        fresh_results.push_back(res);
                        if (reload_len[i] != '0) begin
                            due_at[i] = now_count + reload_len[i];
                        end else begin
                            live[i] = 1'b0;
                        end
                    end
                end
                if (fresh_results.size() > 0) begin
                    fresh_results[fresh_results.size() - 1].last = 1'b1;
                end
            end
            OP_CONFIGURE, OP_START: begin
                if (idx < NUM_TIMERS) begin
                    if (it.op == OP_CONFIGURE) begin
                        reload_len[idx] = it.period;
                        live[idx] = 1'b0;
                    end
                    if (it.delay != '0) begin
                        due_at[idx] = now_count + it.delay;
                        live[idx] = 1'b1;
                    end
                end
            end
            OP_STOP: begin
                if (idx < NUM_TIMERS) begin
                    live[idx] = 1'b0;
                end
            end
            OP_QUERY: begin
                best = ALL_ONES;
                any = 1'b0;
                for (int i = 0; i < NUM_TIMERS; i++) begin
                    if (live[i]) begin
                        gap = due_at[i] - now_count;
                        any = 1'b1;
                        if (gap < best) begin
                            best = gap;
                        end
                    end
                end
                res = '{KIND_QUERY, '0, any ? best : '0, 1'b1};
                fresh_results.push_back(res);
            end
            default: begin
            end
        endcase
    endtask

    task automatic send_item(input in_item_t it, input logic typed, input out_item_t want);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_data = it;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        model_item(it);
        if (typed) begin
            awaited_results.push_back(want);
        end else begin
            foreach (fresh_results[i]) awaited_results.push_back(fresh_results[i]);
        end
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_valid = 1'b0;
        while (awaited_results.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic add_row(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                           input logic [CNT_W-1:0] delay, input logic [CNT_W-1:0] period,
                           input logic typed = 1'b0, input out_item_t want = '0);
        dir_row_t row;
        row.item  = '{op, id, delay, period};
        row.typed = typed;
        row.want  = want;
        directed_rows.push_back(row);
    endtask

    function automatic in_item_t pick_item();
        in_item_t    it;
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 40) begin
            it.op = OP_TICK;
        end else if (r < 55) begin
            it.op = OP_CONFIGURE;
        end else if (r < 68) begin
            it.op = OP_START;
        end else if (r < 76) begin
            it.op = OP_STOP;
        end else if (r < 92) begin
            it.op = OP_QUERY;
        end else begin
            it.op = OP_W'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST));
        end
        it.timer_id = ID_W'($urandom_range(0, (1 << ID_W) - 1));
        r = $urandom_range(0, 99);
        if (r < 85) begin
            it.delay = CNT_W'($urandom_range(1, 12));
        end else if (r < 90) begin
            it.delay = '0;
        end else begin
            it.delay = $urandom;
        end
        r = $urandom_range(0, 99);
        if (r < 50) begin
            it.period = CNT_W'($urandom_range(1, 10));
        end else if (r < 80) begin
            it.period = '0;
        end else begin
            it.period = $urandom;
        end
        return it;
    endfunction

    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            result_count = result_count + 1;
            if (awaited_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result %p", m_data));
            end else begin
                want = awaited_results.pop_front();
                if (m_data.kind !== want.kind)
                    report_mismatch($sformatf("kind %0b, expected %0b",
                                              m_data.kind, want.kind));
                if (m_data.expired_id !== want.expired_id)
                    report_mismatch($sformatf("expired_id %0d, expected %0d",
                                              m_data.expired_id, want.expired_id));
                if (m_data.remaining !== want.remaining)
                    report_mismatch($sformatf("remaining %0h, expected %0h",
                                              m_data.remaining, want.remaining));
                if (m_data.last !== want.last)
                    report_mismatch($sformatf("last %0b, expected %0b",
                                              m_data.last, want.last));
            end
        end
    end

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_ready = 1'b0;
                hold_left = hold_left - 1;
            end else begin
                m_ready = ($urandom_range(0, 99) >= sink_stall_pct);
            end
        end
    end

    initial begin
        in_item_t    it;
        int unsigned sent;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        src_idle_pct = 0;
        sink_stall_pct = 0;
        hold_left = 0;
        cycle_count = 0;
        error_count = 0;
        result_count = 0;
        now_count = '0;
        for (int i = 0; i < NUM_TIMERS; i++) begin
            due_at[i] = '0;
            reload_len[i] = '0;
            live[i] = 1'b0;
        end

        add_row(OP_QUERY, 0, 0, 0, 1'b1, '{KIND_QUERY, '0, '0, 1'b1});
        add_row(OP_TICK, 0, 0, 0);
        add_row(OP_START, 15, ALL_ONES, 0);
        add_row(OP_QUERY, 0, 0, 0, 1'b1, '{KIND_QUERY, '0, ALL_ONES, 1'b1});
        add_row(OP_START, 0, 0, ALL_ONES);
        add_row(OP_CONFIGURE, 3, 1, ALL_ONES);
        add_row(OP_QUERY, 0, 0, 0, 1'b1, '{KIND_QUERY, '0, 1, 1'b1});
        add_row(OP_TICK, 0, 0, 0, 1'b1, '{KIND_EXPIRY, 3, '0, 1'b1});
        add_row(OP_QUERY, 0, 0, 0);
        add_row(OP_STOP, 15, 0, 0);
        add_row(OP_STOP, 3, 0, 0);
        add_row(OP_STOP, 9, 0, 0);
        add_row(OP_QUERY, 0, 0, 0, 1'b1, '{KIND_QUERY, '0, '0, 1'b1});
        add_row(OP_CONFIGURE, 0, 2, 1);
        add_row(OP_CONFIGURE, 7, 2, 0);
        add_row(OP_CONFIGURE, 15, 2, 2);
        add_row(OP_START, 7, 0, 0);
        add_row(OP_TICK, 0, 0, 0);
        add_row(OP_TICK, 0, 0, 0);
        add_row(OP_TICK, 0, 0, 0);
        add_row(OP_TICK, 0, 0, 0);
        add_row(OP_RSVD_FIRST, 15, ALL_ONES, ALL_ONES);
        add_row(OP_RSVD_FIRST + 1'b1, 0, 1, 1);
        add_row(OP_RSVD_LAST, 7, 1, 0);
        add_row(OP_CONFIGURE, 15, 0, 0);
        add_row(OP_QUERY, 0, 0, 0);
        add_row(OP_STOP, 0, 0, 0);

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (directed_rows[i]) begin
            send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
        end
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            src_idle_pct = src_pct_tab[ph];
            sink_stall_pct = sink_pct_tab[ph];
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                it = pick_item();
                send_item(it, 1'b0, '0);
                if (it.op <= OP_QUERY) begin
                    sent = sent + 1;
                end
            end
            wait_drained();
        end

        // Every timer fires on every tick while the result side is held off, so
        // the block has to back-pressure the input until the hold is released.
        src_idle_pct = 0;
        sink_stall_pct = 0;
        for (int i = 0; i < NUM_TIMERS; i++) begin
            send_item('{OP_CONFIGURE, ID_W'(i), CNT_W'(1), CNT_W'(1)}, 1'b0, '0);
        end
        hold_left = HOLD_CYCLES;
        for (int i = 0; i < PRESSURE_TICKS; i++) begin
            send_item('{OP_TICK, '0, '0, '0}, 1'b0, '0);
        end
        send_item('{OP_QUERY, '0, '0, '0}, 1'b0, '0);
        wait_drained();

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (awaited_results.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", awaited_results.size()));
        end
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

[filelist.f]
hdl/htw_pkg.sv
hdl/htw_alu.sv
hdl/htw_store.sv
hdl/hierarchical_timer_wheel_unit.sv
sim/testbench.sv
